### rtl/median_filter_2d_unit_defines.svh
// ----------------------------------------------------------------------------
// Median filter assertion macros
// Shared property wrappers for the median filter RTL.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_2D_UNIT_DEFINES_SVH
`define MEDIAN_FILTER_2D_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define MF2D_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MF2D_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/mf2d_pkg.sv
// ----------------------------------------------------------------------------
// Median filter package
// Fixed port widths, register indexes and reset values.
// ----------------------------------------------------------------------------
package mf2d_pkg;

  localparam int CFG_INDEX_W    = 1;
  localparam int CFG_DATA_W     = 13;
  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 13;
  localparam int PIXEL_W        = 8;
  localparam int ROW_W          = 12;
  localparam int OUT_COL_W      = 10;
  localparam int CMP_W          = 14;

  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd1024;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd480;
  localparam logic [FRAME_HEIGHT_W-1:0] MAX_HEIGHT         = 13'd4096;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

endpackage

### rtl/mf2d_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data (read-old on collision).
// ----------------------------------------------------------------------------
module mf2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/median_filter_2d_unit.sv
// Pipeline: a taken pixel's result passes through line store read, window shift,
//   compare, rank and output select into the output register.
// Throughput: one pixel per cycle unless the output is held; one line store read
//   and write-back per pixel, with a one-entry bypass for a repeated next column.
// Reset (rst, synchronous): counters, window and pipeline valids clear, frame
//   size returns to 1024 x 480; the line store has no reset and is only
//   consumed once rewritten in the current frame.
// ----------------------------------------------------------------------------
// Median filter, square window
// Raster-order grey pixel stream in, median of each full window out.
// ----------------------------------------------------------------------------
`include "median_filter_2d_unit_defines.svh"

module median_filter_2d_unit import mf2d_pkg::*; #(
  parameter int WINDOW     = 3,
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // config
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // pixel input
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [PIXEL_W-1:0]     pixel,
  // result output
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [PIXEL_W-1:0]     median_value,
  output logic [ROW_W-1:0]       centre_row,
  output logic [OUT_COL_W-1:0]   centre_col
);

  localparam int TAPS   = WINDOW * WINDOW;
  localparam int HALF   = WINDOW / 2;
  localparam int MID    = TAPS / 2;
  localparam int LINES  = WINDOW - 1;
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RANK_W = $clog2(TAPS);
  localparam int MEM_W  = LINES * PIXEL_BITS;

  // --------------------------------------------------------------------------
  // Global pipeline enable: everything moves unless the output word is held.
  // --------------------------------------------------------------------------
  logic advance;
  logic accept;

  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;
  assign accept   = in_valid && advance;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [FRAME_WIDTH_W-1:0]  frame_width;
  logic [FRAME_HEIGHT_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FRAME_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FRAME_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Raster counters. Sizes clamp to MAX_WIDTH / 4096; a column counter at or
  // past the width (after a mid-frame write) wraps at the next pixel, the row
  // counter likewise at the end of the row.
  logic [CW-1:0]    col_count;
  logic [ROW_W-1:0] row_count;
  logic [CMP_W-1:0] width_eff, height_eff, col_inc, row_inc;
  logic             col_wrap, row_wrap, emit0;

  always_comb begin
    width_eff  = (CMP_W'(frame_width) > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH)
                                                           : CMP_W'(frame_width);
    height_eff = (frame_height > MAX_HEIGHT) ? CMP_W'(MAX_HEIGHT)
                                             : CMP_W'(frame_height);
    col_inc    = CMP_W'(col_count) + CMP_W'(1);
    row_inc    = CMP_W'(row_count) + CMP_W'(1);
    col_wrap   = col_inc >= width_eff;
    row_wrap   = row_inc >= height_eff;
    emit0      = (CMP_W'(row_count) >= CMP_W'(WINDOW - 1)) &&
                 (CMP_W'(col_count) >= CMP_W'(WINDOW - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_count <= '0;
        row_count <= row_wrap ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_count <= col_inc[CW-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: line store read data is back. Rows above sit packed in one word,
  // oldest row in the low lane.
  // --------------------------------------------------------------------------
  logic                  s1_valid, s1_emit, fwd_hit;
  logic [PIXEL_BITS-1:0] s1_pix;
  logic [CW-1:0]         s1_col, s1_ccol;
  logic [ROW_W-1:0]      s1_crow;
  logic [MEM_W-1:0]      fwd_data, ram_rdata, ram_wdata, line_rd;
  logic                  ram_we;
  logic [PIXEL_BITS-1:0] col_pix [WINDOW];

  assign ram_we  = s1_valid && advance;
  assign line_rd = fwd_hit ? fwd_data : ram_rdata;

  always_comb begin
    for (int k = 0; k < LINES; k++) begin
      col_pix[k] = line_rd[k*PIXEL_BITS +: PIXEL_BITS];
    end
    col_pix[LINES] = s1_pix;
    for (int k = 0; k < LINES; k++) begin
      ram_wdata[k*PIXEL_BITS +: PIXEL_BITS] = col_pix[k+1];
    end
  end

  mf2d_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_col),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (col_count),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
      // same column written this edge: RAM returns stale data, so bypass
      if (in_valid) begin
        fwd_hit <= s1_valid && (s1_col == col_count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix   <= PIXEL_BITS'(pixel);
      s1_col   <= col_count;
      s1_emit  <= emit0;
      s1_crow  <= row_count - ROW_W'(HALF);
      s1_ccol  <= col_count - CW'(HALF);
      fwd_data <= ram_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Window shift (stage 1 -> 2)
  // --------------------------------------------------------------------------
  logic [PIXEL_BITS-1:0] win [WINDOW][WINDOW];
  logic                  s2_valid;
  logic [ROW_W-1:0]      s2_crow;
  logic [CW-1:0]         s2_ccol;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < WINDOW; r++) begin
        for (int c = 0; c < WINDOW; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (ram_we) begin
      for (int r = 0; r < WINDOW; r++) begin
        for (int c = 0; c < WINDOW - 1; c++) begin
          win[r][c] <= win[r][c+1];
        end
        win[r][WINDOW-1] <= col_pix[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_crow <= s1_crow;
      s2_ccol <= s1_ccol;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: all pairwise compares. Ties break on tap index, so each tap
  // gets a distinct rank.
  // --------------------------------------------------------------------------
  logic [PIXEL_BITS-1:0] taps [TAPS];
  logic [TAPS-1:0]       less [TAPS];
  logic [TAPS-1:0]       s3_less [TAPS];
  logic [PIXEL_BITS-1:0] s3_taps [TAPS];
  logic                  s3_valid;
  logic [ROW_W-1:0]      s3_crow;
  logic [CW-1:0]         s3_ccol;

  always_comb begin
    for (int r = 0; r < WINDOW; r++) begin
      for (int c = 0; c < WINDOW; c++) begin
        taps[r*WINDOW + c] = win[r][c];
      end
    end
    for (int i = 0; i < TAPS; i++) begin
      for (int j = 0; j < TAPS; j++) begin
        less[i][j] = (taps[j] < taps[i]) || ((taps[j] == taps[i]) && (j < i));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_less <= less;
      s3_taps <= taps;
      s3_crow <= s2_crow;
      s3_ccol <= s2_ccol;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: rank of each tap
  // --------------------------------------------------------------------------
  logic [RANK_W-1:0]     rank [TAPS];
  logic [RANK_W-1:0]     s4_rank [TAPS];
  logic [PIXEL_BITS-1:0] s4_taps [TAPS];
  logic                  s4_valid;
  logic [ROW_W-1:0]      s4_crow;
  logic [CW-1:0]         s4_ccol;

  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      rank[i] = '0;
      for (int j = 0; j < TAPS; j++) begin
        rank[i] = rank[i] + RANK_W'(s3_less[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (advance) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_rank <= rank;
      s4_taps <= s3_taps;
      s4_crow <= s3_crow;
      s4_ccol <= s3_ccol;
    end
  end

  // --------------------------------------------------------------------------
  // Output: one-hot select of the middle rank into the output register
  // --------------------------------------------------------------------------
  logic [PIXEL_BITS-1:0] med;

  always_comb begin
    med = '0;
    for (int i = 0; i < TAPS; i++) begin
      if (s4_rank[i] == RANK_W'(MID)) begin
        med = med | s4_taps[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s4_valid) begin
      median_value <= med[PIXEL_W-1:0];
      centre_row   <= s4_crow;
      centre_col   <= OUT_COL_W'(s4_ccol);
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // bypass flag is only fresh right after the word that set it was taken
  `MF2D_ASSERT_NOW(a_fwd_same_col, fwd_hit && s1_valid && $past(accept),
                   $past(ram_we) && ($past(s1_col) == s1_col),
                   "bypass without matching write")
  `MF2D_ASSERT_NEXT(a_out_follows, s4_valid && advance, out_valid,
                    "result lost at output register")

endmodule

### tb/median_filter_2d_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Median filter testbench
// Streams small frames through the 3x3 median filter across several frame
// sizes and handshake idling mixes. A behavioral model of the line stores
// and window computes each expected median word and its centre position.
// ----------------------------------------------------------------------------
module median_filter_2d_unit_tb;
  import mf2d_pkg::*;

  localparam int WIN       = 3;
  localparam int LINE_MAX  = 1024;
  localparam int LATENCY   = 5;

  typedef struct packed {
    logic [PIXEL_W-1:0]   med;
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
  } median_word_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [PIXEL_W-1:0]     pixel = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [PIXEL_W-1:0]     median_value;
  logic [ROW_W-1:0]       centre_row;
  logic [OUT_COL_W-1:0]   centre_col;

  always #2 clk = ~clk;

  median_filter_2d_unit i_dut (.*);

  // model state
  logic [10:0]        fw;
  logic [12:0]        fh;
  logic [PIXEL_W-1:0] rows_above [WIN-1][LINE_MAX];
  logic [PIXEL_W-1:0] win_px [WIN][WIN];
  int unsigned        col_cnt, row_cnt;

  median_word_t pending_medians[$];
  median_word_t last_word;
  bit           failed = 1'b0;
  int           send_idle_pct = 0, recv_idle_pct = 0;

  // model: one pixel in, zero or one median word out
  task automatic model_pixel(input logic [PIXEL_W-1:0] px);
    logic [PIXEL_W-1:0] newcol [WIN];
    logic [PIXEL_W-1:0] srt [WIN*WIN];
    logic [PIXEL_W-1:0] tmp;
    int unsigned ew, eh, ci, n;
    median_word_t w;
    ew = (fw > LINE_MAX) ? LINE_MAX : fw;
    eh = (fh > 4096) ? 4096 : fh;
    ci = (col_cnt < LINE_MAX) ? col_cnt : LINE_MAX - 1;
    for (int k = 0; k < WIN - 1; k++) newcol[k] = rows_above[k][ci];
    newcol[WIN-1] = px;
    for (int k = 0; k < WIN - 1; k++) rows_above[k][ci] = newcol[k+1];
    for (int r = 0; r < WIN; r++) begin
      for (int c = 0; c < WIN - 1; c++) win_px[r][c] = win_px[r][c+1];
      win_px[r][WIN-1] = newcol[r];
    end
    if (row_cnt >= WIN - 1 && col_cnt >= WIN - 1) begin
      n = 0;
      for (int r = 0; r < WIN; r++)
        for (int c = 0; c < WIN; c++) srt[n++] = win_px[r][c];
      for (int i = 0; i < WIN*WIN; i++)
        for (int j = 0; j < WIN*WIN - 1 - i; j++)
          if (srt[j] > srt[j+1]) begin
            tmp = srt[j]; srt[j] = srt[j+1]; srt[j+1] = tmp;
          end
      w.med = srt[WIN*WIN/2];
      w.row = ROW_W'(row_cnt - WIN/2);
      w.col = OUT_COL_W'(col_cnt - WIN/2);
      pending_medians.push_back(w);
    end
    if (col_cnt + 1 >= ew) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= eh) ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
  endtask

  // receiver: random stall, compare each accepted word
  always @(negedge clk) begin
    if (!rst) out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    median_word_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      last_word = '{median_value, centre_row, centre_col};
      if (pending_medians.size() == 0) begin
        $error("unexpected word: med %0d row %0d col %0d",
               median_value, centre_row, centre_col);
        failed = 1'b1;
      end else begin
        exp_w = pending_medians.pop_front();
        if (median_value !== exp_w.med) begin
          $error("median_value: expected %0d, got %0d", exp_w.med, median_value);
          failed = 1'b1;
        end
        if (centre_row !== exp_w.row) begin
          $error("centre_row: expected %0d, got %0d", exp_w.row, centre_row);
          failed = 1'b1;
        end
        if (centre_col !== exp_w.col) begin
          $error("centre_col: expected %0d, got %0d", exp_w.col, centre_col);
          failed = 1'b1;
        end
      end
    end
  end

  // one pixel through the handshake; model updated at acceptance.
  // valid stays high after the word so back-to-back words need no gap.
  task automatic send_pixel(input logic [PIXEL_W-1:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_pixel(px);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_medians.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // register write, only with the pipeline empty; enable left high
  task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(negedge clk);
    if (idx == REG_FRAME_WIDTH) fw = 11'(val);
    else fh = 13'(val);
  endtask

  // new frame size; counters are at zero only if the prior frame was sent
  // whole, otherwise they wrap at the new size like the hardware
  task automatic set_frame(input int unsigned w, input int unsigned h);
    drain();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  task automatic random_frame(input int unsigned w, input int unsigned h);
    int unsigned mode;
    mode = $urandom_range(3);
    for (int i = 0; i < w*h; i++) begin
      case (mode)
        0: send_pixel(PIXEL_W'($urandom));
        1: send_pixel($urandom_range(1) ? 8'hFF : 8'h00);       // salt and pepper
        2: send_pixel(PIXEL_W'(i * 7));                          // ramp
        default: send_pixel(PIXEL_W'($urandom_range(120, 135)));  // near-flat
      endcase
    end
  endtask

  // directed frame: 3x3, extremes; one word, median of the nine values
  localparam logic [PIXEL_W-1:0] DIRECTED_PX [9] = '{
    8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h80};

  initial begin
    int unsigned w, h, sent;
    fw = FRAME_WIDTH_RESET;
    fh = FRAME_HEIGHT_RESET;
    col_cnt = 0;
    row_cnt = 0;
    for (int r = 0; r < WIN; r++)
      for (int c = 0; c < WIN; c++) win_px[r][c] = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // smallest frame; median of {FF,00,FF,00,FF,00,AA,55,80} is 80 at (1,1)
    set_frame(3, 3);
    for (int i = 0; i < 9; i++) send_pixel(DIRECTED_PX[i]);
    drain();
    if (last_word.med !== 8'h80) begin
      $error("median_value: expected %0d, got %0d", 8'h80, last_word.med);
      failed = 1'b1;
    end
    if (last_word.row !== ROW_W'(1)) begin
      $error("centre_row: expected %0d, got %0d", 1, last_word.row);
      failed = 1'b1;
    end
    if (last_word.col !== OUT_COL_W'(1)) begin
      $error("centre_col: expected %0d, got %0d", 1, last_word.col);
      failed = 1'b1;
    end

    // width below window: nothing emitted, counters wrap
    set_frame(2, 4);
    for (int i = 0; i < 8; i++) send_pixel(8'hFF);
    // width and height zero: counters wrap on every pixel, no output
    set_frame(0, 0);
    for (int i = 0; i < 4; i++) send_pixel(8'h00);
    set_frame(4, 3);
    for (int i = 0; i < 12; i++) send_pixel(PIXEL_W'(i * 21));

    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 84 : 0;
      recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 14 : 0;
      while (sent < (phase + 1) * 500) begin
        w = ($urandom_range(9) == 0) ? $urandom_range(3, 40) : $urandom_range(3, 8);
        h = $urandom_range(3, 6);
        set_frame(w, h);   // sender pause till all words are in
        random_frame(w, h);
        sent += w * h;
      end
    end
    // oversize width clamps to the line length; first part of a row only
    set_frame(2047, 3);
    for (int i = 0; i < 120; i++) send_pixel(PIXEL_W'($urandom));
    // counters wrap at the new width; height clamps to 4096
    set_frame(5, 8191);
    random_frame(5, 4);
    drain();

    if (!failed && pending_medians.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
